>>> rtl/crc8fr_pkg.sv
// Shared types, codes and the CRC-8 byte update for the frame receiver.
package crc8fr_pkg;

  localparam int unsigned CfgAddrW = 4;

  localparam logic [1:0] KIND_FUNCT  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_ADDR = 3'd1;
  localparam logic [2:0] ST_END_ERR  = 3'd2;
  localparam logic [2:0] ST_CRC_ERR  = 3'd3;
  localparam logic [2:0] ST_LEN_ERR  = 3'd4;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_ADDR  = 2'd2;

  localparam logic [7:0]  CRC_INIT  = 8'hFF;
  localparam logic [7:0]  CRC_POLY  = 8'h31;
  localparam logic [15:0] MIN_LEN   = 16'd8;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [31:0] own_address;
  } cfg_t;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (x[7]) begin
        x = {x[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[6:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage

>>> rtl/crc8fr_regs.sv
// Configuration register file with its APB-style access port.
module crc8fr_regs import crc8fr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output cfg_t                cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= 8'h02;
      cfg_r.end_byte    <= 8'h03;
      cfg_r.own_address <= 32'h0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START: cfg_r.start_byte  <= cfg_pwdata[7:0];
        REG_END:   cfg_r.end_byte    <= cfg_pwdata[7:0];
        REG_ADDR:  cfg_r.own_address <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START: cfg_prdata = {24'h0, cfg_r.start_byte};
      REG_END:   cfg_prdata = {24'h0, cfg_r.end_byte};
      REG_ADDR:  cfg_prdata = cfg_r.own_address;
      default:   cfg_prdata = 32'h0;
    endcase
  end

endmodule

>>> rtl/crc8fr_core.sv
// Input byte register, frame parser with running CRC, and result register.
module crc8fr_core import crc8fr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic       out_last
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_ADDR  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_FUNCT = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CRC   = 3'd5;
  localparam logic [2:0] PH_END   = 3'd6;

  localparam logic [15:0] ADDR_LAST = 16'd3;
  localparam logic [15:0] LEN_LAST  = 16'd1;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        adv;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  rcrc_r, rcrc_nxt;
  logic        match_r, match_nxt;

  logic        res_v;
  logic [1:0]  res_kind;
  logic [7:0]  res_data;
  logic [2:0]  res_status;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_byte_r;
  logic [2:0]  out_status_r;
  logic        out_last_r;

  logic [7:0]  crc_upd;
  logic [31:0] addr_sh;
  logic [15:0] len_sh;
  logic [15:0] cnt_inc;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_byte;
    end
  end

  assign crc_upd = crc8_next(crc_r, s1_byte_r);
  assign addr_sh = {addr_r[23:0], s1_byte_r};
  assign len_sh  = {len_r[7:0], s1_byte_r};
  assign cnt_inc = cnt_r + 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    addr_nxt   = addr_r;
    len_nxt    = len_r;
    rcrc_nxt   = rcrc_r;
    match_nxt  = match_r;
    res_v      = 1'b0;
    res_kind   = KIND_FUNCT;
    res_data   = 8'h0;
    res_status = ST_OK;
    case (phase_r)
      PH_ADDR: begin
        crc_nxt  = crc_upd;
        addr_nxt = addr_sh;
        cnt_nxt  = cnt_inc;
        if (cnt_r == ADDR_LAST) begin
          match_nxt = (addr_sh == cfg.own_address);
          cnt_nxt   = 16'd0;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        crc_nxt = crc_upd;
        len_nxt = len_sh;
        cnt_nxt = cnt_inc;
        if (cnt_r == LEN_LAST) begin
          cnt_nxt = 16'd0;
          if (len_sh < MIN_LEN) begin
            phase_nxt  = PH_HUNT;
            res_v      = 1'b1;
            res_kind   = KIND_STATUS;
            res_status = ST_LEN_ERR;
          end else begin
            phase_nxt = PH_FUNCT;
          end
        end
      end
      PH_FUNCT: begin
        crc_nxt   = crc_upd;
        cnt_nxt   = 16'd0;
        phase_nxt = (len_r == MIN_LEN) ? PH_CRC : PH_DATA;
        res_v     = match_r;
        res_kind  = KIND_FUNCT;
        res_data  = s1_byte_r;
      end
      PH_DATA: begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= len_r - MIN_LEN) begin
          cnt_nxt   = 16'd0;
          phase_nxt = PH_CRC;
        end
        res_v    = match_r;
        res_kind = KIND_DATA;
        res_data = s1_byte_r;
      end
      PH_CRC: begin
        rcrc_nxt  = s1_byte_r;
        phase_nxt = PH_END;
      end
      PH_END: begin
        phase_nxt = PH_HUNT;
        res_v     = 1'b1;
        res_kind  = KIND_STATUS;
        if (s1_byte_r != cfg.end_byte) begin
          res_status = ST_END_ERR;
        end else if (rcrc_r != crc_r) begin
          res_status = ST_CRC_ERR;
        end else if (!match_r) begin
          res_status = ST_NOT_ADDR;
        end else begin
          res_status = ST_OK;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (s1_byte_r == cfg.start_byte) begin
          crc_nxt   = CRC_INIT;
          cnt_nxt   = 16'd0;
          addr_nxt  = 32'h0;
          len_nxt   = 16'd0;
          rcrc_nxt  = 8'h0;
          match_nxt = 1'b0;
          phase_nxt = PH_ADDR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= 16'd0;
      crc_r   <= CRC_INIT;
      addr_r  <= 32'h0;
      len_r   <= 16'd0;
      rcrc_r  <= 8'h0;
      match_r <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
      rcrc_r  <= rcrc_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_v;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_v) begin
      out_kind_r   <= res_kind;
      out_byte_r   <= res_data;
      out_status_r <= res_status;
      out_last_r   <= (res_kind == KIND_STATUS);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  a_fwd_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_v && res_kind != KIND_STATUS |-> match_r)
    else $error("forwarded byte without address match");

  a_crc_then_end: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == PH_CRC |=> phase_r == PH_END)
    else $error("CRC byte not followed by end phase");

  a_start_inits: assert property (@(posedge clk) disable iff (!rst_n)
    adv && phase_r == PH_HUNT && s1_byte_r == cfg.start_byte
    |=> phase_r == PH_ADDR && crc_r == CRC_INIT && cnt_r == 16'd0)
    else $error("frame start did not initialize parser");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r == KIND_STATUS)))
    else $error("last flag does not match status beat");

endmodule

>>> rtl/crc8_frame_receiver.sv
// Top level of the CRC-8 checked start/end framed byte receiver.
//
//  port group | dir     | beat contents
//  in_*       | sink    | tdata[7:0] rx_byte
//  out_*      | source  | tdata[7:0] data_byte, [10:8] status; tuser kind; tlast last
//  cfg_*      | APB     | 0x0 start_byte, 0x4 end_byte, 0x8 own_address
//
// One beat per cycle sustained while no out_ beat is stalled; a byte passes from in_ to out_
// through the input register, then the parser and result register.
// rst_n is synchronous; the parser resets to hunting with CRC at 0xFF.
// A stalled out_ beat holds the input register; in_tready drops only then.
module crc8_frame_receiver import crc8fr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,    // [7:0] rx_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,   // [7:0] data_byte, [10:8] status, [15:11] zero
  output logic [1:0]          out_tuser,   // [1:0] kind
  output logic                out_tlast,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  cfg_t       cfg;
  logic [7:0] res_data;
  logic [2:0] res_status;

  crc8fr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  crc8fr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kind   (out_tuser),
    .out_byte   (res_data),
    .out_status (res_status),
    .out_last   (out_tlast)
  );

  assign out_tdata = {5'b0, res_status, res_data};

endmodule
